### hw/rtl/neighbor_difference_energy_map_defines.svh
// Assertion macros shared by the energy map RTL.
`ifndef NEIGHBOR_DIFFERENCE_ENERGY_MAP_DEFINES_SVH
`define NEIGHBOR_DIFFERENCE_ENERGY_MAP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define NDEM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("energy map check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define NDEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("energy map check failed");

`endif

### hw/rtl/ndem_pkg.sv
// Types, constants and neighbor tables shared by the energy map modules.
`default_nettype none

package ndem_pkg;

	// Field and arithmetic widths.
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int SUM_W  = 13;
	localparam int DIVS_W = 5;
	localparam int CNT_W  = 4;
	localparam int K_W    = 4;
	localparam int FW_W   = 11;
	localparam int FH_W   = 12;
	localparam int CFG_W  = 12;

	// One window pass reads the center and then eight neighbors.
	localparam logic [K_W-1:0] K_LAST = 4'd8;

	// Configuration register indexes.
	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	// Divider request and response.
	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CH_W-1:0]  quotient;
	} div_rsp_t;

	// Row offset of window step k; step zero is the center pixel.
	function automatic logic signed [1:0] nb_dr(input logic [K_W-1:0] k);
		logic signed [1:0] r;
		case (k)
			4'd1, 4'd2, 4'd3: r = -2'sd1;
			4'd6, 4'd7, 4'd8: r = 2'sd1;
			default: r = 2'sd0;
		endcase
		return r;
	endfunction

	// Column offset of window step k.
	function automatic logic signed [1:0] nb_dc(input logic [K_W-1:0] k);
		logic signed [1:0] c;
		case (k)
			4'd1, 4'd4, 4'd6: c = -2'sd1;
			4'd3, 4'd5, 4'd8: c = 2'sd1;
			default: c = 2'sd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ndem_divider.sv
// Restoring divider that turns the difference sum into the mean energy.
`default_nettype none

module ndem_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ndem_pkg::div_req_t req,
	output ndem_pkg::div_rsp_t      rsp
);
	import ndem_pkg::*;

	logic [SUM_W-1:0]  dvd_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] divisor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   rem_sh;
	logic              fits;

	// One quotient bit per cycle: shift in the next dividend bit and try a subtract.
	always_comb begin
		rem_sh = {rem_q, dvd_q[SUM_W-1]};
		fits   = (rem_sh >= {1'b0, divisor_q});
	end

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath; the quotient bits shift into the dividend register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
			rem_q <= fits ? DIVS_W'(rem_sh - {1'b0, divisor_q}) : DIVS_W'(rem_sh);
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q[CH_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/neighbor_difference_energy_map.sv
// A pixel word that completes a window, or a drain word with a result pending, runs a window pass:
// the sequencer reads the center and eight neighbors through the one read port of the pixel ring,
// then a bit-serial divide gives the mean, and the result waits while the output word is held.
// The block takes no new word until that result is written to the output register.
// A pixel word that gives no result, or a drain word with nothing pending, is taken in the idle state.
// Reset clears positions, pending count and output valid and loads a 640 by 480 frame.
`default_nettype none

module neighbor_difference_energy_map #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       kind,
	input  wire logic [ndem_pkg::CH_W-1:0]  red,
	input  wire logic [ndem_pkg::CH_W-1:0]  green,
	input  wire logic [ndem_pkg::CH_W-1:0]  blue,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [ndem_pkg::CH_W-1:0]       energy,
	output logic                            frame_last,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic                       cfg_index,
	input  wire logic [ndem_pkg::CFG_W-1:0] cfg_data
);
	import ndem_pkg::*;

	`include "neighbor_difference_energy_map_defines.svh"

	localparam int RING_D = 2 * MAX_WIDTH + 2;
	localparam int AW     = $clog2(RING_D);
	localparam int OFS_W  = AW + 2;
	localparam int PEND_W = $clog2(MAX_WIDTH + 2);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam logic signed [OFS_W-1:0] RING_S = OFS_W'(RING_D);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_READ   = 3'd1;
	localparam logic [2:0] S_LAST   = 3'd2;
	localparam logic [2:0] S_DSTART = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	// Pixel ring memory.
	logic [PIX_W-1:0] ring_mem [RING_D];
	logic [PIX_W-1:0] rd_data_q;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [PIX_W-1:0] wr_data;

	logic [2:0]        state_q;
	logic [FW_W-1:0]   frame_width_q;
	logic [FH_W-1:0]   frame_height_q;
	logic [AW-1:0]     ring_wr_q;
	logic [PEND_W-1:0] pending_q;
	logic [FH_W-1:0]   orow_q;
	logic [COL_W-1:0]  ocol_q;
	logic [PIX_W-1:0]  px_q;
	logic              pix_q;
	logic [PIX_W-1:0]  me_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  n_q;
	logic [K_W-1:0]    step_q;
	logic              valid_s1;
	logic [K_W-1:0]    step_s1;
	logic              present_s1;
	logic              use_in_s1;
	logic              out_valid_q;
	logic [CH_W-1:0]   energy_q;
	logic              frame_last_q;

	logic [WID_W-1:0]        eff_w;
	logic [FH_W-1:0]         eff_h;
	logic                    in_acc;
	logic                    out_free;
	logic                    win_full;
	logic signed [1:0]       dr;
	logic signed [1:0]       dc;
	logic signed [OFS_W-1:0] w_s;
	logic signed [OFS_W-1:0] pend_s;
	logic signed [OFS_W-1:0] d_ofs;
	logic signed [OFS_W-1:0] limit_s;
	logic signed [OFS_W-1:0] addr_raw;
	logic signed [OFS_W-1:0] addr_fix;
	logic                    present;
	logic                    use_in;
	logic [PIX_W-1:0]        nb;
	logic                    is_last_px;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	// Sum of the three absolute channel differences between two pixels.
	function automatic logic [9:0] diff3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
		logic [9:0]      acc;
		logic [CH_W-1:0] x;
		logic [CH_W-1:0] y;
		acc = '0;
		for (int c = 0; c < 3; c++) begin
			x   = a[c*CH_W +: CH_W];
			y   = b[c*CH_W +: CH_W];
			acc = acc + 10'((x > y) ? (x - y) : (y - x));
		end
		return acc;
	endfunction

	// Effective frame size: width clamped to one..MAX_WIDTH, height at least one.
	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = WID_W'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			eff_w = WID_W'(MAX_WIDTH);
		end else begin
			eff_w = WID_W'(frame_width_q);
		end
		eff_h = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign win_full  = (32'(pending_q) >= 32'(eff_w) + 32'd1);

	// Window step: ring address, presence inside the frame and the incoming-pixel tap.
	always_comb begin
		dr     = nb_dr(step_q);
		dc     = nb_dc(step_q);
		w_s    = signed'(OFS_W'(eff_w));
		pend_s = signed'(OFS_W'(pending_q));
		case (dr)
			2'sd1:   d_ofs = w_s + OFS_W'(dc);
			-2'sd1:  d_ofs = OFS_W'(dc) - w_s;
			default: d_ofs = OFS_W'(dc);
		endcase
		limit_s  = pix_q ? pend_s : (pend_s - OFS_W'(1));
		addr_raw = signed'(OFS_W'(ring_wr_q)) - pend_s + d_ofs;
		if (addr_raw < 0) begin
			addr_fix = addr_raw + RING_S;
		end else if (addr_raw >= RING_S) begin
			addr_fix = addr_raw - RING_S;
		end else begin
			addr_fix = addr_raw;
		end
		rd_addr = AW'(addr_fix);
		present = 1'b1;
		if (dr < 0 && orow_q == '0) present = 1'b0;
		if (dr > 0 && 32'(orow_q) + 32'd1 >= 32'(eff_h)) present = 1'b0;
		if (dc < 0 && ocol_q == '0) present = 1'b0;
		if (dc > 0 && 32'(ocol_q) + 32'd1 >= 32'(eff_w)) present = 1'b0;
		if (d_ofs > limit_s) present = 1'b0;
		if (step_q == '0) present = 1'b1;
		use_in = pix_q && (d_ofs == pend_s) && (step_q != '0);
	end

	assign nb         = use_in_s1 ? px_q : rd_data_q;
	assign is_last_px = (32'(orow_q) == 32'(eff_h) - 32'd1) &&
	                    (32'(ocol_q) == 32'(eff_w) - 32'd1);

	// Ring write: a pixel is stored at once when it gives no result, else after its window pass.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = {red, green, blue};
		if (in_acc && !kind && !win_full) begin
			wr_en = 1'b1;
		end else if (state_q == S_FIN && out_free && pix_q) begin
			wr_en   = 1'b1;
			wr_data = px_q;
		end
		wr_addr = ring_wr_q;
	end

	// Ring memory with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= ring_mem[rd_addr];
	end

	// Divider request for the sum over three times the neighbor count.
	always_comb begin
		div_req.start    = (state_q == S_DSTART);
		div_req.dividend = sum_q;
		div_req.divisor  = DIVS_W'({n_q, 1'b0}) + DIVS_W'(n_q);
	end

	ndem_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(640);
			frame_height_q <= FH_W'(480);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, ring pointer, pending count and output position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ring_wr_q   <= '0;
			pending_q   <= '0;
			orow_q      <= '0;
			ocol_q      <= '0;
			step_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (in_acc) begin
						if (!kind && !win_full) begin
							ring_wr_q <= (32'(ring_wr_q) == RING_D - 1) ? '0 : ring_wr_q + 1'b1;
							pending_q <= pending_q + 1'b1;
						end else if (!kind || pending_q != '0) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					valid_s1 <= 1'b1;
					step_q   <= step_q + 1'b1;
					if (step_q == K_LAST) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					valid_s1 <= 1'b0;
					state_q  <= S_DSTART;
				end
				S_DSTART: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (32'(ocol_q) + 32'd1 >= 32'(eff_w)) begin
							ocol_q <= '0;
							if (32'(orow_q) + 32'd1 >= 32'(eff_h)) begin
								orow_q <= '0;
							end else begin
								orow_q <= orow_q + 1'b1;
							end
						end else begin
							ocol_q <= ocol_q + 1'b1;
						end
						if (pix_q) begin
							ring_wr_q <= (32'(ring_wr_q) == RING_D - 1) ? '0 : ring_wr_q + 1'b1;
						end else begin
							pending_q <= pending_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item word capture, window accumulation and the output word.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q  <= {red, green, blue};
			pix_q <= !kind;
			sum_q <= '0;
			n_q   <= '0;
		end
		step_s1    <= step_q;
		present_s1 <= present;
		use_in_s1  <= use_in;
		if (valid_s1) begin
			if (step_s1 == '0) begin
				me_q <= rd_data_q;
			end else if (present_s1) begin
				sum_q <= sum_q + SUM_W'(diff3(me_q, nb));
				n_q   <= n_q + 1'b1;
			end
		end
		if (state_q == S_FIN && out_free) begin
			energy_q     <= (n_q == '0) ? '0 : div_rsp.quotient;
			frame_last_q <= is_last_px;
		end
	end

	assign out_valid  = out_valid_q;
	assign energy     = energy_q;
	assign frame_last = frame_last_q;

	// A finished result waits in place while the output word is still held.
	`NDEM_ASSERT_NEXT(a_fin_stall, clk, arst_n, state_q == S_FIN && !out_free, state_q == S_FIN)
	// A pixel that completes a window always starts a window pass.
	`NDEM_ASSERT_NEXT(a_full_reads, clk, arst_n, in_acc && !kind && win_full, state_q == S_READ)
	// The divider only finishes while the sequencer waits for it.
	`NDEM_ASSERT_NOW(a_div_done, clk, arst_n, div_rsp.done, state_q == S_DIV)
	// The ring write pointer stays inside the memory.
	`NDEM_ASSERT_NOW(a_ring_ptr, clk, arst_n, 1'b1, 32'(ring_wr_q) < RING_D)

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the neighbor difference energy map.
`timescale 1ns / 100ps

module tb_top;

	import ndem_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int RING_DEPTH    = 2 * MAX_W + 2;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PIXELS = 600;
	localparam int TALL_ROWS     = 300;
	localparam int WIDE_PIXELS   = 64;
	localparam int LIMIT_NS      = 8_000_000;
	localparam int PRINT_CAP     = 200;

	// Word kinds on the input channel.
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// Pixel content styles for generated frames.
	localparam int FILL_RANDOM  = 0;
	localparam int FILL_EXTREME = 1;
	localparam int FILL_NEAR    = 2;

	typedef struct {
		logic       kind;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} stream_word_t;

	typedef struct {
		logic [7:0] energy;
		logic       last;
	} energy_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = KIND_PIXEL;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  energy;
	logic        frame_last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_FRAME_WIDTH;
	logic [11:0] cfg_data = '0;

	neighbor_difference_energy_map #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.energy(energy),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Words waiting to be sent and energies waiting to be seen.
	stream_word_t word_q[$];
	energy_word_t energy_q[$];
	int fail_count = 0;

	task automatic flag_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Copy of the block's state: pixel ring, held pixels, answer position, registers.
	logic [23:0] pix_ring [RING_DEPTH];
	int          ring_wr_ptr = 0;
	int          held_count = 0;
	int          ans_row = 0;
	int          ans_col = 0;
	logic [10:0] width_reg = 11'd640;
	logic [11:0] height_reg = 12'd480;

	function automatic int span_width(input logic [10:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_W)
			return MAX_W;
		return int'(raw);
	endfunction

	function automatic int span_height(input logic [11:0] raw);
		return (raw == 0) ? 1 : int'(raw);
	endfunction

	function automatic int chan_gap(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? int'(a - b) : int'(b - a);
	endfunction

	// Computes the energy of the oldest held pixel; neighbors farther ahead than reach
	// have not arrived and are left out, and the neighbor at held_count is new_px.
	task automatic answer_oldest(input bit with_new, input logic [23:0] new_px,
			input int reach);
		int w, h, base, d, sum, cnt, dr, dc;
		logic [23:0] me, nb;
		energy_word_t e;
		w = span_width(width_reg);
		h = span_height(height_reg);
		base = (ring_wr_ptr + RING_DEPTH - held_count) % RING_DEPTH;
		me = pix_ring[base];
		sum = 0;
		cnt = 0;
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				d = dr * w + dc;
				if ((dr != 0 || dc != 0) && !(dr < 0 && ans_row == 0)
						&& !(dr > 0 && ans_row + 1 >= h) && !(dc < 0 && ans_col == 0)
						&& !(dc > 0 && ans_col + 1 >= w) && d <= reach) begin
					if (with_new && d == held_count)
						nb = new_px;
					else
						nb = pix_ring[(base + RING_DEPTH + d) % RING_DEPTH];
					sum += chan_gap(me[23:16], nb[23:16]) + chan_gap(me[15:8], nb[15:8])
						+ chan_gap(me[7:0], nb[7:0]);
					cnt += 3;
				end
			end
		end
		e.energy = (cnt == 0) ? 8'd0 : 8'(sum / cnt);
		e.last = (ans_row == h - 1 && ans_col == w - 1);
		energy_q.push_back(e);
		ans_col++;
		if (ans_col >= w) begin
			ans_col = 0;
			ans_row++;
			if (ans_row >= h)
				ans_row = 0;
		end
		held_count--;
	endtask

	// Updates the state copy for one accepted input word.
	task automatic predict_word(input logic k, input logic [23:0] px);
		int w;
		w = span_width(width_reg);
		if (k == KIND_PIXEL) begin
			if (held_count >= w + 1)
				answer_oldest(1'b1, px, held_count);
			pix_ring[ring_wr_ptr] = px;
			ring_wr_ptr = (ring_wr_ptr + 1) % RING_DEPTH;
			held_count++;
		end else if (held_count > 0) begin
			answer_oldest(1'b0, '0, held_count - 1);
		end
	endtask

	// Register writes seen on the configuration channel.
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_FRAME_WIDTH)
				width_reg = cfg_data[10:0];
			else
				height_reg = cfg_data;
		end
	end

	// Input driver: bursts of random length separated by random gaps.
	stream_word_t nxt_word;
	int burst_left = 0;
	int idle_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_word(kind, {red, green, blue});
			if (!in_valid || in_ready) begin
				if (idle_left == 0 && word_q.size() != 0) begin
					nxt_word = word_q.pop_front();
					in_valid <= 1'b1;
					kind <= nxt_word.kind;
					red <= nxt_word.r;
					green <= nxt_word.g;
					blue <= nxt_word.b;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						idle_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
					if (idle_left > 0)
						idle_left--;
				end
			end
		end
	end

	// Output monitor: checks each energy word and stalls on a changing pattern.
	energy_word_t want;
	logic [7:0] stall_pat = 8'hFF;
	int stall_tick = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (energy_q.size() == 0) begin
					flag_mismatch($sformatf("energy word %0d with none expected", energy));
				end else begin
					want = energy_q.pop_front();
					if (energy !== want.energy)
						flag_mismatch($sformatf("energy %0d, expected %0d", energy, want.energy));
					if (frame_last !== want.last)
						flag_mismatch($sformatf("frame_last %0b, expected %0b", frame_last,
							want.last));
				end
			end
			stall_tick++;
			if (stall_tick % 50 == 0)
				stall_pat = ($urandom_range(2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			out_ready <= stall_pat[stall_tick % 8];
		end
	end

	// Generator-side view of the frame size and of the pixels still held.
	int gen_w = 640;
	int gen_h = 480;
	int gen_pending = 0;
	int near_base = 0;

	function automatic logic [7:0] pick_chan(input int mode);
		case (mode)
			FILL_EXTREME: return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
			FILL_NEAR: return 8'(near_base + $urandom_range(6) - 3);
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		stream_word_t wd;
		wd.kind = KIND_PIXEL;
		wd.r = r;
		wd.g = g;
		wd.b = b;
		word_q.push_back(wd);
		if (gen_pending < gen_w + 1)
			gen_pending++;
	endtask

	task automatic send_drain();
		stream_word_t wd;
		wd.kind = KIND_DRAIN;
		wd.r = 8'($urandom);
		wd.g = 8'($urandom);
		wd.b = 8'($urandom);
		word_q.push_back(wd);
		if (gen_pending > 0)
			gen_pending--;
	endtask

	task automatic flush_pending();
		while (gen_pending > 0)
			send_drain();
	endtask

	// Whole frames of pixels, with early drains mixed in at random when odds is set.
	task automatic feed_frames(input int nframes, input int mode, input int odds);
		int total;
		total = nframes * gen_w * gen_h;
		near_base = $urandom_range(255);
		for (int i = 0; i < total; i++) begin
			if (odds != 0 && $urandom_range(odds - 1) == 0)
				send_drain();
			send_pixel(pick_chan(mode), pick_chan(mode), pick_chan(mode));
		end
	endtask

	// Holds the sender until every word is taken and every energy has come out.
	task automatic settle();
		do begin
			@(posedge clk);
			#1;
		end while (word_q.size() != 0 || in_valid || energy_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [11:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FRAME_WIDTH)
			gen_w = span_width(val[10:0]);
		else
			gen_h = span_height(val);
	endtask

	// Stimulus sequence and final verdict.
	initial begin
		int rand_pixels, nframes, odds;
		logic [11:0] raw_w, raw_h;
		bit first;
		for (int i = 0; i < RING_DEPTH; i++)
			pix_ring[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Small frame with full-scale channel values, an idle drain and an early drain.
		write_reg(CFG_FRAME_WIDTH, 12'd3);
		write_reg(CFG_FRAME_HEIGHT, 12'd3);
		send_drain();
		for (int i = 0; i < 3; i++)
			send_pixel((i & 1) ? 8'hFF : 8'h00, (i & 2) ? 8'hFF : 8'h00,
				(i & 1) ? 8'h00 : 8'hFF);
		// The lower neighbors of the first pixel have not arrived yet.
		send_drain();
		settle();
		for (int i = 3; i < 9; i++)
			send_pixel((i & 1) ? 8'hFF : 8'h00, (i & 2) ? 8'hFF : 8'h00,
				(i & 4) ? 8'hFF : 8'h00);
		flush_pending();
		settle();

		// Zero-sized registers act as a single pixel with no neighbors.
		write_reg(CFG_FRAME_WIDTH, 12'd0);
		write_reg(CFG_FRAME_HEIGHT, 12'd0);
		send_pixel(8'hA5, 8'h5A, 8'hFF);
		send_drain();

		// Random small frames, sometimes several in a row and with early drains.
		rand_pixels = 0;
		first = 1'b1;
		while (rand_pixels < RANDOM_PIXELS) begin
			settle();
			case ($urandom_range(9))
				0: raw_w = 12'd0;
				1: raw_w = 12'($urandom_range(9, 24));
				default: raw_w = 12'($urandom_range(1, 8));
			endcase
			raw_w[11] = 1'($urandom_range(1));
			raw_h = 12'($urandom_range(0, (raw_w[10:0] > 8) ? 3 : 6));
			if ($urandom_range(1) == 0) begin
				if (first || $urandom_range(3) != 0)
					write_reg(CFG_FRAME_WIDTH, raw_w);
				write_reg(CFG_FRAME_HEIGHT, raw_h);
			end else begin
				if (first || $urandom_range(3) != 0)
					write_reg(CFG_FRAME_HEIGHT, raw_h);
				write_reg(CFG_FRAME_WIDTH, raw_w);
			end
			first = 1'b0;
			nframes = $urandom_range(1, 3);
			odds = ($urandom_range(1) == 0) ? 0 : $urandom_range(8, 30);
			feed_frames(nframes, $urandom_range(FILL_RANDOM, FILL_NEAR), odds);
			rand_pixels += nframes * gen_w * gen_h;
			flush_pending();
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 2)) send_drain();
		end

		// Tall frame, one pixel per row.
		settle();
		write_reg(CFG_FRAME_WIDTH, 12'd1);
		write_reg(CFG_FRAME_HEIGHT, 12'(TALL_ROWS));
		feed_frames(1, FILL_RANDOM, 200);
		flush_pending();

		// An oversized width register clamps to the widest row; a partial row ends the run.
		settle();
		write_reg(CFG_FRAME_WIDTH, 12'h7FF);
		write_reg(CFG_FRAME_HEIGHT, 12'd1);
		for (int i = 0; i < WIDE_PIXELS; i++)
			send_pixel(pick_chan(FILL_RANDOM), pick_chan(FILL_RANDOM), pick_chan(FILL_RANDOM));
		flush_pending();

		settle();
		if (fail_count == 0 && energy_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#LIMIT_NS;
		$display("simulation failed");
		$finish;
	end

endmodule
